// ===== sv/rrts_pkg.sv =====
// Package for the round-robin thread scheduler: request, status and
// thread-state codes plus fixed field widths. No dependencies.
package rrts_pkg;

    localparam int TID_W    = 4;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 3;
    localparam int SLICE_W  = 20;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 20'd1500;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD      = 3'd0,
        REQ_REMOVE   = 3'd1,
        REQ_SUSPEND  = 3'd2,
        REQ_WAKEUP   = 3'd3,
        REQ_SCHEDULE = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_EXITED    = 3'd1,
        STS_LAST      = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_BAD_STATE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        TS_UNUSED    = 2'd0,
        TS_READY     = 2'd1,
        TS_SUSPENDED = 2'd2,
        TS_FINISHED  = 2'd3
    } t_tstate;

endpackage

// ===== sv/round_robin_thread_scheduler_unit.sv =====
// The request passes through the input register and then the result register.
// Throughput: one request per cycle while the result channel is not stalled; the ring pointer
// update is a single pass of logic between the input register and the result register, and
// the input register can take a new request while a result waits. Reset (synchronous, active
// low) clears all thread states, the ring head, count and scheduling flags and sets the slice
// length to 1500; ring links are left undefined until written.
// Top level of the round-robin thread scheduler.
// Depends on rrts_pkg.
module round_robin_thread_scheduler_unit
    import rrts_pkg::*;
#(
    parameter int MAX_THREADS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [TID_W-1:0]    i_thread_id,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [TID_W-1:0]    o_scheduled_id,
    output logic                o_scheduled_valid,
    output logic                o_start_timer,
    output logic [SLICE_W-1:0]  o_timer_cycles,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SLICE_W-1:0]  i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);

    // map an out-of-range slot value back to slot zero
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] v);
        slot_of = (32'(v) < MAX_THREADS) ? v : '0;
    endfunction

    // scheduler state
    t_tstate          r_tstate [MAX_THREADS];
    t_tstate          n_tstate [MAX_THREADS];
    logic [IDX_W-1:0] r_next   [MAX_THREADS];
    logic [IDX_W-1:0] n_next   [MAX_THREADS];
    logic [IDX_W-1:0] r_prev   [MAX_THREADS];
    logic [IDX_W-1:0] n_prev   [MAX_THREADS];
    logic [IDX_W-1:0] r_cur, n_cur;
    logic             r_cur_valid, n_cur_valid;
    logic             r_adv, n_adv;
    logic [IDX_W-1:0] r_first, n_first;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SLICE_W-1:0] r_slice;

    // input register
    logic             r_in_valid;
    logic [REQ_W-1:0] r_req;
    logic [TID_W-1:0] r_tid;

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [TID_W-1:0]    r_out_id;
    logic                r_out_sched_valid;
    logic                r_out_timer;
    logic [SLICE_W-1:0]  r_out_cycles;

    logic    w_advance;
    logic    w_exec;
    t_status w_status;
    logic    w_timer;

    // handshake: execute when a request is held and the result slot is free
    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_exec      = r_in_valid && w_advance;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // compute next scheduler state and result for the held request
    always_comb begin
        logic [31:0]      tid_w;
        logic [IDX_W-1:0] t;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] nx;
        logic             in_range;
        t_tstate          st;
        logic             do_enq;
        logic             do_take;
        logic             take_ok;
        logic             at_head;

        n_tstate    = r_tstate;
        n_next      = r_next;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_adv       = r_adv;
        n_first     = r_first;
        n_cnt       = r_cnt;
        w_status    = STS_OK;
        w_timer     = 1'b0;

        tid_w    = 32'(r_tid);
        t        = tid_w[IDX_W-1:0];
        in_range = tid_w < MAX_THREADS;
        st       = r_tstate[t];
        do_enq   = 1'b0;
        do_take  = 1'b0;
        at_head  = 1'b0;
        b        = '0;
        p        = '0;
        nx       = slot_of(r_next[t]);
        take_ok  = !(r_cur_valid && (r_cur == t) && (nx == t));

        // decode the request
        if (w_exec) begin
            case (t_req'(r_req))
                REQ_SCHEDULE: begin
                    if (!r_cur_valid) begin
                        if (r_cnt == '0) begin
                            w_status = STS_EMPTY;
                        end else begin
                            n_cur       = r_first;
                            n_cur_valid = 1'b1;
                            n_adv       = 1'b0;
                        end
                    end else if (r_adv) begin
                        n_adv = 1'b0;
                    end else begin
                        n_cur = slot_of(r_next[slot_of(r_cur)]);
                    end
                end
                REQ_ADD: begin
                    if (!in_range || st == TS_READY || st == TS_SUSPENDED) begin
                        w_status = STS_BAD_STATE;
                    end else begin
                        do_enq = 1'b1;
                    end
                end
                REQ_REMOVE: begin
                    if (!in_range) begin
                        w_status = STS_BAD_STATE;
                    end else if (st == TS_READY) begin
                        if (take_ok) begin
                            do_take     = 1'b1;
                            n_tstate[t] = TS_FINISHED;
                        end else begin
                            w_status = STS_LAST;
                        end
                    end else if (st == TS_SUSPENDED) begin
                        n_tstate[t] = TS_FINISHED;
                    end else begin
                        w_status = STS_BAD_STATE;
                    end
                end
                REQ_SUSPEND: begin
                    if (!in_range || st != TS_READY) begin
                        w_status = STS_BAD_STATE;
                    end else if (take_ok) begin
                        do_take     = 1'b1;
                        n_tstate[t] = TS_SUSPENDED;
                    end else begin
                        w_status = STS_LAST;
                    end
                end
                REQ_WAKEUP: begin
                    if (!in_range) begin
                        w_status = STS_BAD_STATE;
                    end else if (st == TS_FINISHED) begin
                        w_status = STS_EXITED;
                    end else if (st == TS_UNUSED) begin
                        w_status = STS_BAD_STATE;
                    end else if (st == TS_SUSPENDED) begin
                        do_enq = 1'b1;
                    end
                end
                default: begin
                    w_status = STS_OK;
                end
            endcase
        end

        // link the thread in before the scheduled thread, or at the tail
        if (do_enq) begin
            n_tstate[t] = TS_READY;
            at_head     = r_cur_valid && (r_cnt != '0) && (r_cur == r_first);
            w_timer     = !r_cur_valid;
            b           = slot_of(r_cur_valid ? r_cur : r_first);
            if (r_cnt == '0) begin
                n_next[t] = t;
                n_prev[t] = t;
                n_first   = t;
            end else begin
                p         = slot_of(r_prev[b]);
                n_next[p] = t;
                n_prev[t] = p;
                n_next[t] = b;
                n_prev[b] = t;
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (at_head) begin
                n_first = t;
            end
        end

        // unlink the thread, stepping off it if it is scheduled
        if (do_take) begin
            if (r_cur_valid && r_cur == t) begin
                n_cur = nx;
                n_adv = 1'b1;
            end
            if (r_cnt <= CNT_W'(1)) begin
                n_cnt = '0;
            end else begin
                p          = slot_of(r_prev[t]);
                n_next[p]  = nx;
                n_prev[nx] = p;
                if (r_first == t) begin
                    n_first = nx;
                end
                n_cnt = r_cnt - CNT_W'(1);
            end
        end
    end

    // hold the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_req <= i_req_type;
            r_tid <= i_thread_id;
        end
    end

    // update control state and thread states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_tstate[i] <= TS_UNUSED;
            end
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_adv       <= 1'b0;
            r_first     <= '0;
            r_cnt       <= '0;
        end else if (w_exec) begin
            r_tstate    <= n_tstate;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_adv       <= n_adv;
            r_first     <= n_first;
            r_cnt       <= n_cnt;
        end
    end

    // ring links carry no reset
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_next <= n_next;
            r_prev <= n_prev;
        end
    end

    // slice length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= SLICE_RESET;
        end else if (i_cfg_valid) begin
            r_slice <= i_cfg_data;
        end
    end

    // capture the result
    always_ff @(posedge i_clk) begin
        logic [31:0] cur_w;
        cur_w = 32'(n_cur);
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_exec) begin
            r_out_status      <= w_status;
            r_out_id          <= n_cur_valid ? cur_w[TID_W-1:0] : '0;
            r_out_sched_valid <= n_cur_valid;
            r_out_timer       <= w_timer;
            r_out_cycles      <= w_timer ? r_slice : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_scheduled_id    = r_out_id;
    assign o_scheduled_valid = r_out_sched_valid;
    assign o_start_timer     = r_out_timer;
    assign o_timer_cycles    = r_out_cycles;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_THREADS)
        else $error("ready count above thread capacity");

    a_adv_needs_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_adv |-> r_cur_valid)
        else $error("advance flag set with nothing scheduled");

    a_sched_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |=> r_cur_valid)
        else $error("scheduling dropped after it started");

    a_timer_before_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_timer) |-> !r_out_sched_valid)
        else $error("timer start reported after scheduling started");

    a_empty_unscheduled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STS_EMPTY) |-> !r_out_sched_valid)
        else $error("empty queue reported while a thread is scheduled");
`endif

endmodule
